// File: hw/rtl/ntg_pkg.sv
// Shared types, constants and the quarter-wave sine table for the note tone generator.
package ntg_pkg;

    localparam int PHASE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF = 22;
    localparam int FADE_LEN_DEF   = 200;

    localparam int LENGTH_BITS  = 22;
    localparam int STEP_BITS    = 23;
    localparam int AMP_BITS     = 15;
    localparam int PHASE_U_BITS = 16;
    localparam int FACTOR_BITS  = 13;
    localparam int SAMPLE_BITS  = 16;
    localparam int QUEUE_DEPTH  = 4;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAWTOOTH = 2'd2,
        WAVE_SINE     = 2'd3
    } wave_t;

    typedef struct packed {
        logic [PHASE_U_BITS-1:0] phase;
        wave_t                   wave;
        logic [AMP_BITS-1:0]     amp;
        logic                    silent;
        logic                    fade_en;
        logic [FACTOR_BITS-1:0]  factor;
        logic                    last;
    } item_t;

    localparam logic [15:0] QUARTER_SINE [65] = '{
        16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
        16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
        16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
        16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
        16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
        16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
        16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
        16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
        16'd32767
    };

endpackage

// File: hw/rtl/ntg_front.sv
// Front end: accepts note requests, updates phase and sample index, classifies the fade.
module ntg_front #(
    parameter int PHASE_BITS = ntg_pkg::PHASE_BITS_DEF,
    parameter int COUNT_BITS = ntg_pkg::COUNT_BITS_DEF,
    parameter int FADE_LEN   = ntg_pkg::FADE_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             queue_full,
    input  logic                             start_req,
    input  logic [ntg_pkg::LENGTH_BITS-1:0]  note_samples,
    input  logic [ntg_pkg::STEP_BITS-1:0]    phase_step,
    input  logic [ntg_pkg::AMP_BITS-1:0]     amplitude,
    input  logic [1:0]                       wave_select,
    output logic                             req_stall,
    output logic                             push,
    output ntg_pkg::item_t                   push_item
);

    localparam int LW = (COUNT_BITS > ntg_pkg::LENGTH_BITS) ? COUNT_BITS : ntg_pkg::LENGTH_BITS;
    localparam int SW = (PHASE_BITS > ntg_pkg::STEP_BITS) ? PHASE_BITS : ntg_pkg::STEP_BITS;
    localparam int CW = (COUNT_BITS > ntg_pkg::FACTOR_BITS) ? COUNT_BITS : ntg_pkg::FACTOR_BITS;

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [COUNT_BITS-1:0] sample_index_reg;
    logic [COUNT_BITS-1:0] sample_index_next;

    logic                  accept;
    logic [PHASE_BITS-1:0] eff_phase;
    logic [COUNT_BITS-1:0] eff_idx;
    logic [COUNT_BITS-1:0] length;
    logic [COUNT_BITS-1:0] rem;
    logic [CW-1:0]         rem_w;
    logic [CW-1:0]         idx_w;
    logic                  live;
    logic [SW-1:0]         phase_sum;
    logic [31:0]           phase_aligned;

    assign req_stall = queue_full;
    assign accept    = req_valid && !req_stall;
    assign eff_phase = start_req ? '0 : phase_acc_reg;
    assign eff_idx   = start_req ? '0 : sample_index_reg;
    assign length    = COUNT_BITS'(LW'(note_samples));
    assign live      = (length != '0) && (eff_idx < length);
    assign rem       = length - eff_idx;
    assign rem_w     = CW'(rem);
    assign idx_w     = CW'(eff_idx);
    assign phase_sum = SW'(eff_phase) + SW'(phase_step);
    assign phase_aligned = 32'(eff_phase) << (32 - PHASE_BITS);
    assign push      = accept && live;

    always_comb
    begin
        push_item.phase   = phase_aligned[31:16];
        push_item.wave    = ntg_pkg::wave_t'(wave_select);
        push_item.amp     = amplitude;
        push_item.silent  = (phase_step == '0);
        push_item.last    = (rem == COUNT_BITS'(1));
        push_item.fade_en = 1'b0;
        push_item.factor  = '0;
        priority if (rem_w <= CW'(FADE_LEN))
        begin
            push_item.fade_en = 1'b1;
            push_item.factor  = ntg_pkg::FACTOR_BITS'(rem_w);
        end
        else if (idx_w < CW'(FADE_LEN))
        begin
            push_item.fade_en = 1'b1;
            push_item.factor  = ntg_pkg::FACTOR_BITS'(idx_w);
        end
        else
        begin
            push_item.fade_en = 1'b0;
            push_item.factor  = '0;
        end
    end

    always_comb
    begin
        phase_acc_next    = phase_acc_reg;
        sample_index_next = sample_index_reg;
        if (accept)
        begin
            phase_acc_next    = eff_phase;
            sample_index_next = eff_idx;
            if (live)
            begin
                phase_acc_next    = PHASE_BITS'(phase_sum);
                sample_index_next = eff_idx + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
        end
        else
        begin
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
        end
    end

    a_empty_note_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && length == '0) |-> !push)
        else $error("empty note produced a queue entry");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> sample_index_reg == $past(eff_idx) + COUNT_BITS'(1))
        else $error("sample index did not advance after a sample");

    a_factor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.fade_en) |-> (32'(push_item.factor) <= 32'(FADE_LEN)))
        else $error("fade factor beyond fade length");

endmodule

// File: hw/rtl/ntg_queue.sv
// Short queue of classified sample jobs between front and back end.
module ntg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ntg_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output ntg_pkg::item_t head_item
);

    localparam int PW = $clog2(ntg_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(ntg_pkg::QUEUE_DEPTH + 1);

    ntg_pkg::item_t entry_reg [ntg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [NW-1:0]  count_reg;
    logic [NW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == NW'(ntg_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/ntg_back.sv
// Back end: waveform, amplitude scaling, fade and output register.
module ntg_back #(
    parameter int FADE_LEN = ntg_pkg::FADE_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    input  ntg_pkg::item_t                      job,
    output logic                                job_pop,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [ntg_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                last
);

    localparam int MW = ntg_pkg::AMP_BITS + ntg_pkg::FACTOR_BITS;
    localparam int LG = $clog2(FADE_LEN);
    localparam int SH = MW + LG;
    localparam int RW = MW + 1;
    localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'(FADE_LEN) - 64'd1) / 64'(FADE_LEN);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    logic en;

    // wave
    logic [1:0]         quad;
    logic [14:0]        r;
    logic [6:0]         tidx;
    logic [6:0]         tidx_n;
    logic [7:0]         frac;
    logic [15:0]        t0;
    logic [15:0]        tdiff;
    logic [23:0]        interp;
    logic [15:0]        sine_mag;
    logic signed [18:0] uu;
    logic signed [18:0] w;
    logic [18:0]        w_abs;

    logic                           s1_valid_reg;
    logic                           s1_neg_reg;
    logic [16:0]                    s1_wmag_reg;
    logic [ntg_pkg::AMP_BITS-1:0]   s1_amp_reg;
    logic                           s1_silent_reg;
    logic                           s1_fade_en_reg;
    logic [ntg_pkg::FACTOR_BITS-1:0] s1_factor_reg;
    logic                           s1_last_reg;

    logic [31:0]                    amp_prod;
    logic                           s2_valid_reg;
    logic                           s2_neg_reg;
    logic [14:0]                    s2_raw_reg;
    logic                           s2_silent_reg;
    logic                           s2_fade_en_reg;
    logic [ntg_pkg::FACTOR_BITS-1:0] s2_factor_reg;
    logic                           s2_last_reg;

    logic                           s3_valid_reg;
    logic                           s3_neg_reg;
    logic [14:0]                    s3_raw_reg;
    logic                           s3_silent_reg;
    logic                           s3_fade_en_reg;
    logic [MW-1:0]                  s3_fprod_reg;
    logic                           s3_last_reg;

    logic                           s4_valid_reg;
    logic                           s4_neg_reg;
    logic [14:0]                    s4_raw_reg;
    logic                           s4_silent_reg;
    logic                           s4_fade_en_reg;
    logic [MW+RW-1:0]               s4_qprod_reg;
    logic                           s4_last_reg;

    logic [14:0]                    final_mag;
    logic signed [ntg_pkg::SAMPLE_BITS-1:0] sample_next;

    logic                           out_valid_reg;
    logic signed [ntg_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic                           last_reg;

    assign en           = !(out_valid_reg && result_stall);
    assign job_pop      = en && job_valid;
    assign result_valid = out_valid_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;

    always_comb
    begin
        quad   = job.phase[15:14];
        r      = {1'b0, job.phase[13:0]};
        if (quad[0])
        begin
            r = 15'd16384 - r;
        end
        tidx   = r[14:8];
        frac   = r[7:0];
        tidx_n = (tidx == 7'd64) ? tidx : tidx + 7'd1;
        t0     = ntg_pkg::QUARTER_SINE[tidx];
        tdiff  = ntg_pkg::QUARTER_SINE[tidx_n] - t0;
        interp = 24'(tdiff) * 24'(frac);
        sine_mag = t0 + 16'(interp >> 8);
        uu     = signed'({3'b000, job.phase});
        unique case (job.wave)
            ntg_pkg::WAVE_SQUARE:
            begin
                w = (job.phase <= 16'd32768) ? 19'sd32768 : -19'sd32768;
            end
            ntg_pkg::WAVE_TRIANGLE:
            begin
                priority if (job.phase < 16'd16384)
                begin
                    w = 19'sd2 * uu;
                end
                else if (job.phase < 16'd49152)
                begin
                    w = 19'sd65536 - 19'sd2 * uu;
                end
                else
                begin
                    w = 19'sd2 * uu - 19'sd131072;
                end
            end
            ntg_pkg::WAVE_SAWTOOTH:
            begin
                w = uu - 19'sd32768;
            end
            ntg_pkg::WAVE_SINE:
            begin
                w = quad[1] ? -signed'({3'b000, sine_mag}) : signed'({3'b000, sine_mag});
            end
            default:
            begin
                w = '0;
            end
        endcase
        w_abs = w[18] ? 19'(-w) : 19'(w);
    end

    assign amp_prod = 32'(s1_amp_reg) * 32'(s1_wmag_reg);

    always_comb
    begin
        final_mag = s4_fade_en_reg ? s4_qprod_reg[SH+14:SH] : s4_raw_reg;
        if (s4_silent_reg)
        begin
            sample_next = '0;
        end
        else if (s4_neg_reg)
        begin
            sample_next = -signed'({1'b0, final_mag});
        end
        else
        begin
            sample_next = signed'({1'b0, final_mag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg     <= w[18];
            s1_wmag_reg    <= w_abs[16:0];
            s1_amp_reg     <= job.amp;
            s1_silent_reg  <= job.silent;
            s1_fade_en_reg <= job.fade_en;
            s1_factor_reg  <= job.factor;
            s1_last_reg    <= job.last;

            s2_neg_reg     <= s1_neg_reg;
            s2_raw_reg     <= amp_prod[29:15];
            s2_silent_reg  <= s1_silent_reg;
            s2_fade_en_reg <= s1_fade_en_reg;
            s2_factor_reg  <= s1_factor_reg;
            s2_last_reg    <= s1_last_reg;

            s3_neg_reg     <= s2_neg_reg;
            s3_raw_reg     <= s2_raw_reg;
            s3_silent_reg  <= s2_silent_reg;
            s3_fade_en_reg <= s2_fade_en_reg;
            s3_fprod_reg   <= MW'(s2_raw_reg) * MW'(s2_factor_reg);
            s3_last_reg    <= s2_last_reg;

            s4_neg_reg     <= s3_neg_reg;
            s4_raw_reg     <= s3_raw_reg;
            s4_silent_reg  <= s3_silent_reg;
            s4_fade_en_reg <= s3_fade_en_reg;
            s4_qprod_reg   <= (MW+RW)'(s3_fprod_reg) * (MW+RW)'(RECIP);
            s4_last_reg    <= s3_last_reg;

            sample_reg     <= sample_next;
            last_reg       <= s4_last_reg;
        end
    end

endmodule

// File: hw/rtl/note_tone_generator_with_fade_unit.sv
// Top level of the note tone generator: front end, job queue and back end.
// A request's sample passes through the job queue, back-end stages s1 to s4 and the output register.
// Throughput: one request per cycle and one sample per cycle while the result side takes them.
// The 4-entry job queue lets the front keep taking requests while the back end is stalled, until it is full.
// A request that yields no sample (empty or finished note) only updates phase and index.
// Reset clears phase and sample index, empties the queue and drops all pending samples.
module note_tone_generator_with_fade_unit #(
    parameter int PHASE_BITS = ntg_pkg::PHASE_BITS_DEF,
    parameter int COUNT_BITS = ntg_pkg::COUNT_BITS_DEF,
    parameter int FADE_LEN   = ntg_pkg::FADE_LEN_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic                                   start_req,
    input  logic [ntg_pkg::LENGTH_BITS-1:0]        note_samples,
    input  logic [ntg_pkg::STEP_BITS-1:0]          phase_step,
    input  logic [ntg_pkg::AMP_BITS-1:0]           amplitude,
    input  logic [1:0]                             wave_select,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [ntg_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                   last
);

    logic           push;
    ntg_pkg::item_t push_item;
    logic           queue_full;
    logic           queue_not_empty;
    logic           pop;
    ntg_pkg::item_t head_item;

    ntg_front #(
        .PHASE_BITS (PHASE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .FADE_LEN   (FADE_LEN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .queue_full   (queue_full),
        .start_req    (start_req),
        .note_samples (note_samples),
        .phase_step   (phase_step),
        .amplitude    (amplitude),
        .wave_select  (wave_select),
        .req_stall    (req_stall),
        .push         (push),
        .push_item    (push_item)
    );

    ntg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    ntg_back #(
        .FADE_LEN (FADE_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (queue_not_empty),
        .job          (head_item),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample       (sample),
        .last         (last)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the note tone generator: random notes, fades, stalls and gaps.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ntg_pkg::*;

    localparam int FADE_SPAN   = FADE_LEN_DEF;
    localparam int NOTE_TARGET = 550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } tone_sample_t;

    class ToneScoreboard;
        bit [PHASE_BITS_DEF-1:0] phase;
        bit [COUNT_BITS_DEF-1:0] index;
        longint                  sine_quarter [65];
        tone_sample_t            due_samples [$];
        int                      errors;

        function new();
            for (int k = 0; k < 65; k++)
            begin
                sine_quarter[k] = longint'($floor(32767.0 * $sin(k * 3.14159265358979 / 128.0)
                                                  + 0.5));
            end
            phase  = '0;
            index  = '0;
            errors = 0;
        endfunction

        function longint wave_level(bit [15:0] u, wave_t sel);
            longint p;
            longint v;
            longint d;
            int     r;
            int     slot;
            int     frac;
            p = longint'(u);
            case (sel)
                WAVE_SQUARE:
                    return (u <= 16'd32768) ? 32768 : -32768;
                WAVE_TRIANGLE:
                begin
                    if (p < 16384)
                        return 2 * p;
                    if (p < 49152)
                        return 65536 - 2 * p;
                    return 2 * p - 131072;
                end
                WAVE_SAWTOOTH:
                    return p - 32768;
                default:
                begin
                    r = int'(u[13:0]);
                    if (u[14])
                        r = 16384 - r;
                    slot = r >> 8;
                    frac = r & 255;
                    v = sine_quarter[slot];
                    if (slot < 64)
                    begin
                        d = sine_quarter[slot + 1] - v;
                        v = v + (d * frac) / 256;
                    end
                    return u[15] ? -v : v;
                end
            endcase
        endfunction

        // Advance the tone state for one request; queue the sample it yields, if any.
        function bit predict_sample(bit start, bit [LENGTH_BITS-1:0] len,
                                    bit [STEP_BITS-1:0] step, bit [AMP_BITS-1:0] amp,
                                    wave_t sel);
            longint       s;
            longint       gain;
            longint       rem_l;
            longint       idx_l;
            bit [COUNT_BITS_DEF-1:0] rem;
            tone_sample_t next;
            if (start)
            begin
                phase = '0;
                index = '0;
            end
            if (len == 0 || index >= len)
                return 0;
            rem   = len - index;
            rem_l = longint'(rem);
            idx_l = longint'(index);
            gain  = longint'(amp);
            if (step == 0)
                s = 0;
            else
            begin
                s = (gain * wave_level(phase[PHASE_BITS_DEF-1 -: 16], sel)) / 32768;
                if (rem_l <= FADE_SPAN)
                    s = (s * rem_l) / FADE_SPAN;
                else if (idx_l < FADE_SPAN)
                    s = (s * idx_l) / FADE_SPAN;
            end
            next.sample = s[SAMPLE_BITS-1:0];
            next.last   = (rem == 1);
            due_samples.insert(due_samples.size(), next);
            phase = phase + step;
            index = index + 1'b1;
            return 1;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic signed [SAMPLE_BITS-1:0] got_sample, logic got_last);
            tone_sample_t exp_s;
            if (due_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected sample %0d last %0b", got_sample,
                                          got_last));
                return;
            end
            exp_s = due_samples.pop_front();
            if (got_sample !== exp_s.sample)
                report_mismatch($sformatf("sample got %0d expected %0d", got_sample,
                                          exp_s.sample));
            if (got_last !== exp_s.last)
                report_mismatch($sformatf("last got %0b expected %0b", got_last, exp_s.last));
        endtask

        function int pending();
            return due_samples.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_stall;
    logic                          start_req;
    logic [LENGTH_BITS-1:0]        note_samples;
    logic [STEP_BITS-1:0]          phase_step;
    logic [AMP_BITS-1:0]           amplitude;
    logic [1:0]                    wave_select;
    logic                          result_valid;
    logic                          result_stall;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    ToneScoreboard sb;
    bit            no_gaps;
    int            sounding;
    int            cycle_count = 0;

    note_tone_generator_with_fade_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .start_req    (start_req),
        .note_samples (note_samples),
        .phase_step   (phase_step),
        .amplitude    (amplitude),
        .wave_select  (wave_select),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample       (sample),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("note_tone_generator_with_fade_unit regression: fail");
        $finish;
    end

    task automatic send_request(bit start, bit [LENGTH_BITS-1:0] len, bit [STEP_BITS-1:0] step,
                                bit [AMP_BITS-1:0] amp, wave_t sel);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start_req    <= start;
        note_samples <= len;
        phase_step   <= step;
        amplitude    <= amp;
        wave_select  <= sel;
        req_valid    <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (sb.predict_sample(start, len, step, amp, sel))
            sounding++;
    endtask

    task automatic drain_samples();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic bit [STEP_BITS-1:0] pick_step();
        int roll;
        roll = $urandom_range(0, 11);
        if (roll == 0)
            return '0;
        if (roll < 4)
            return STEP_BITS'($urandom_range(1, 4095));
        return STEP_BITS'($urandom_range(0, (1 << STEP_BITS) - 1));
    endfunction

    function automatic bit [AMP_BITS-1:0] pick_amp();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return '0;
        if (roll < 3)
            return 15'd32767;
        return AMP_BITS'($urandom_range(0, 32767));
    endfunction

    task automatic play_note(bit long_note);
        int                     n;
        int                     mode;
        int                     idx_now;
        bit                     start;
        bit [LENGTH_BITS-1:0]   fixed_len;
        bit [LENGTH_BITS-1:0]   len;
        bit [STEP_BITS-1:0]     step;
        bit [AMP_BITS-1:0]      amp;
        wave_t                  sel;
        n = (long_note || $urandom_range(0, 9) == 0) ? $urandom_range(220, 300)
                                                     : $urandom_range(1, 40);
        mode      = long_note ? 2 : $urandom_range(0, 3);
        fixed_len = (mode == 0) ? LENGTH_BITS'(n)
                                : LENGTH_BITS'($urandom_range(0, (1 << LENGTH_BITS) - 1));
        no_gaps   = ($urandom_range(0, 3) == 0);
        step      = pick_step();
        amp       = pick_amp();
        sel       = wave_t'($urandom_range(0, 3));
        for (int k = 0; k < n; k++)
        begin
            start = (k == 0) || ($urandom_range(0, 49) == 0);
            idx_now = start ? 0 : int'(sb.index);
            case (mode)
                0, 1: len = fixed_len;
                2: len = LENGTH_BITS'(idx_now + $urandom_range(0, 260));
                default: len = ($urandom_range(0, 7) == 0)
                               ? '0
                               : LENGTH_BITS'($urandom_range(0, (1 << LENGTH_BITS) - 1));
            endcase
            if ($urandom_range(0, 3) == 0)
                sel = wave_t'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                amp = pick_amp();
            if ($urandom_range(0, 9) == 0)
                step = pick_step();
            send_request(start, len, step, amp, sel);
        end
        if (mode == 0)
            repeat ($urandom_range(0, 2))
                send_request(1'b0, fixed_len, step, amp, sel);
    endtask

    initial
    begin
        wave_t sel;
        sb           = new();
        sounding     = 0;
        no_gaps      = 1'b0;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        start_req    <= 1'b0;
        note_samples <= '0;
        phase_step   <= '0;
        amplitude    <= '0;
        wave_select  <= WAVE_SQUARE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(1'b1, 22'd3, 23'h7FFFFF, 15'd32767, WAVE_SQUARE);
        send_request(1'b0, 22'd3, 23'h7FFFFF, 15'd32767, WAVE_TRIANGLE);
        send_request(1'b0, 22'd3, 23'h7FFFFF, 15'd0, WAVE_SAWTOOTH);
        send_request(1'b0, 22'd3, 23'd100, 15'd5, WAVE_SINE);
        send_request(1'b1, 22'd0, 23'd1, 15'd1, WAVE_SQUARE);
        send_request(1'b0, 22'd2, 23'd0, 15'd32767, WAVE_SINE);
        send_request(1'b0, 22'd2, 23'd0, 15'd32767, WAVE_SINE);
        send_request(1'b1, 22'h3FFFFF, 23'h7FFFFF, 15'd32767, WAVE_SINE);
        for (int w = 0; w < 4; w++)
        begin
            sel = wave_t'(w);
            for (int k = 0; k < 5; k++)
                send_request(k == 0, 22'(k + FADE_SPAN), 23'h400000, 15'd32767, sel);
        end
        drain_samples();

        play_note(1'b1);
        while (sounding < NOTE_TARGET / 2)
            play_note(1'b0);
        drain_samples();
        while (sounding < NOTE_TARGET)
            play_note(1'b0);
        drain_samples();

        if (sb.errors == 0)
            $display("note_tone_generator_with_fade_unit regression: pass");
        else
            $display("note_tone_generator_with_fade_unit regression: fail");
        $finish;
    end

    initial
    begin
        int hold;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 5);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            sb.check_result(sample, last);
        end
    end

endmodule

// File: sim.f
hw/rtl/ntg_pkg.sv
hw/rtl/ntg_front.sv
hw/rtl/ntg_queue.sv
hw/rtl/ntg_back.sv
hw/rtl/note_tone_generator_with_fade_unit.sv
tb/testbench.sv
